// ===== rtl/six_step_commutation_ramp_defines.svh =====
`ifndef SIX_STEP_COMMUTATION_RAMP_DEFINES_SVH
`define SIX_STEP_COMMUTATION_RAMP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ssc_pkg.sv =====
package ssc_pkg;

    localparam int PERIOD_BITS = 16;

    // floor(p / 1000) as (p * MS_RECIP) >> MS_SHIFT, exact for any PERIOD_BITS-bit p
    localparam int MS_SHIFT = PERIOD_BITS + 10;
    localparam logic [PERIOD_BITS:0] MS_RECIP =
        (PERIOD_BITS + 1)'(((64'd1 << MS_SHIFT) + 64'd999) / 64'd1000);

    localparam int unsigned MS_ABOVE    = 32'd16380;
    localparam int unsigned GEAR2_BELOW = 32'd39950;
    localparam int unsigned GEAR3_BELOW = 32'd20000;
    localparam int unsigned GEAR4_BELOW = 32'd3000;
    localparam int unsigned GEAR5_BELOW = 32'd1100;
    localparam int unsigned GEAR6_BELOW = 32'd1000;

    localparam logic [2:0] GEAR_FIRST  = 3'd1;
    localparam logic [2:0] GEAR_SECOND = 3'd2;
    localparam logic [2:0] GEAR_THIRD  = 3'd3;
    localparam logic [2:0] GEAR_FOURTH = 3'd4;
    localparam logic [2:0] GEAR_FIFTH  = 3'd5;
    localparam logic [2:0] GEAR_SIXTH  = 3'd6;

    localparam logic [2:0] STAGE_FIRST = 3'd0;
    localparam logic [2:0] STAGE_LAST  = 3'd5;

    localparam int NUM_DECS = 5;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_PERIOD = 3'd0;
    localparam logic [2:0] CFG_MIN_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_FIRST_DEC    = 3'd2;
    localparam logic [2:0] CFG_SECOND_DEC   = 3'd3;
    localparam logic [2:0] CFG_THIRD_DEC    = 3'd4;
    localparam logic [2:0] CFG_FOURTH_DEC   = 3'd5;
    localparam logic [2:0] CFG_FIFTH_DEC    = 3'd6;

    localparam logic [15:0] RST_START_PERIOD = 16'd40000;
    localparam logic [15:0] RST_MIN_PERIOD   = 16'd900;
    localparam logic [11:0] RST_FIRST_DEC    = 12'd50;
    localparam logic [11:0] RST_SECOND_DEC   = 12'd300;
    localparam logic [11:0] RST_THIRD_DEC    = 12'd50;
    localparam logic [11:0] RST_FOURTH_DEC   = 12'd2;
    localparam logic [11:0] RST_FIFTH_DEC    = 12'd1;

    typedef struct packed {
        logic tick;
        logic restart;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  phase_drive;
        logic [2:0]  stage_number;
        logic [2:0]  gear_number;
        logic [15:0] current_period;
        logic        stage_began;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_push;

    // Phase levels per stage: LLH, HLH, HLL, HHL, LHL, LHH (bit0 = phase one)
    function automatic logic [2:0] stage_phases(input logic [2:0] stage);
        logic [2:0] p;
        case (stage)
            3'd0:    p = 3'b100;
            3'd1:    p = 3'b101;
            3'd2:    p = 3'b001;
            3'd3:    p = 3'b011;
            3'd4:    p = 3'b010;
            default: p = 3'b110;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/ssc_core.sv =====
module ssc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  ssc_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output ssc_pkg::t_push      o_push
);

    localparam int PB = ssc_pkg::PERIOD_BITS;

    logic [15:0]   r_start_period;
    logic [15:0]   r_min_period;
    logic [11:0]   r_dec [ssc_pkg::NUM_DECS];

    logic [PB-1:0] r_period,   n_period;
    logic [PB-1:0] r_elapsed,  n_elapsed;
    logic [2:0]    r_stage,    n_stage;
    logic [2:0]    r_gear,     n_gear;
    logic [PB-1:0] r_duration, n_duration;

    logic [2*PB:0] ms_prod;
    logic [PB-1:0] ms_quot;
    logic [PB+9:0] ms_quot_x;
    logic [PB+9:0] ms_floor;
    logic [PB-1:0] dur_raw;

    logic [PB:0]   elapsed_inc;
    logic          hit;
    logic [2:0]    dec_idx;
    logic [PB-1:0] dec;
    logic [PB-1:0] min_p;
    logic [PB-1:0] adj_period;
    logic [2:0]    level;
    logic          began;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_period <= ssc_pkg::RST_START_PERIOD;
            r_min_period   <= ssc_pkg::RST_MIN_PERIOD;
            r_dec[0]       <= ssc_pkg::RST_FIRST_DEC;
            r_dec[1]       <= ssc_pkg::RST_SECOND_DEC;
            r_dec[2]       <= ssc_pkg::RST_THIRD_DEC;
            r_dec[3]       <= ssc_pkg::RST_FOURTH_DEC;
            r_dec[4]       <= ssc_pkg::RST_FIFTH_DEC;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssc_pkg::CFG_START_PERIOD: r_start_period <= i_cfg_data;
                ssc_pkg::CFG_MIN_PERIOD:   r_min_period   <= i_cfg_data;
                ssc_pkg::CFG_FIRST_DEC:    r_dec[0]       <= i_cfg_data[11:0];
                ssc_pkg::CFG_SECOND_DEC:   r_dec[1]       <= i_cfg_data[11:0];
                ssc_pkg::CFG_THIRD_DEC:    r_dec[2]       <= i_cfg_data[11:0];
                ssc_pkg::CFG_FOURTH_DEC:   r_dec[3]       <= i_cfg_data[11:0];
                ssc_pkg::CFG_FIFTH_DEC:    r_dec[4]       <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Stage length from the period, refreshed every cycle. It is registered, so it
    // lags a period change into the next cycle; such a change only ever lands with elapsed at zero.
    always_comb begin
        ms_prod   = (2*PB+1)'(r_period) * (2*PB+1)'(ssc_pkg::MS_RECIP);
        ms_quot   = PB'(ms_prod >> ssc_pkg::MS_SHIFT);
        ms_quot_x = (PB+10)'(ms_quot);
        ms_floor  = (ms_quot_x << 10) - (ms_quot_x << 4) - (ms_quot_x << 3);
        dur_raw   = (32'(r_period) > ssc_pkg::MS_ABOVE) ? PB'(ms_floor) : r_period;
        n_duration = (dur_raw == '0) ? PB'(1) : dur_raw;
    end

    always_comb begin
        elapsed_inc = {1'b0, r_elapsed} + (PB+1)'(1);
        // With elapsed at zero the stage ends only for a one-tick duration
        if (r_elapsed == '0) begin
            hit = (r_period <= PB'(1));
        end else begin
            hit = (elapsed_inc >= {1'b0, r_duration});
        end

        dec_idx = (r_gear >= ssc_pkg::GEAR_FIFTH) ? 3'd4 :
                  ((r_gear == '0) ? 3'd0 : r_gear - 3'd1);
        dec     = PB'(r_dec[dec_idx]);
        min_p   = PB'(r_min_period);

        if (r_period > min_p) begin
            adj_period = (r_period >= dec) ? r_period - dec : '0;
        end else begin
            adj_period = min_p;
        end

        if (32'(adj_period) < ssc_pkg::GEAR6_BELOW) begin
            level = ssc_pkg::GEAR_SIXTH;
        end else if (32'(adj_period) < ssc_pkg::GEAR5_BELOW) begin
            level = ssc_pkg::GEAR_FIFTH;
        end else if (32'(adj_period) < ssc_pkg::GEAR4_BELOW) begin
            level = ssc_pkg::GEAR_FOURTH;
        end else if (32'(adj_period) < ssc_pkg::GEAR3_BELOW) begin
            level = ssc_pkg::GEAR_THIRD;
        end else if (32'(adj_period) < ssc_pkg::GEAR2_BELOW) begin
            level = ssc_pkg::GEAR_SECOND;
        end else begin
            level = ssc_pkg::GEAR_FIRST;
        end

        n_period  = r_period;
        n_elapsed = r_elapsed;
        n_stage   = r_stage;
        n_gear    = r_gear;
        began     = 1'b0;

        if (i_item.restart) begin
            n_period  = PB'(r_start_period);
            n_gear    = ssc_pkg::GEAR_FIRST;
            n_stage   = ssc_pkg::STAGE_FIRST;
            n_elapsed = '0;
            began     = 1'b1;
        end else if (i_item.tick) begin
            if (hit) begin
                n_elapsed = '0;
                began     = 1'b1;
                if (r_stage >= ssc_pkg::STAGE_LAST) begin
                    n_period = adj_period;
                    n_gear   = (level > r_gear) ? level : r_gear;
                    n_stage  = ssc_pkg::STAGE_FIRST;
                end else begin
                    n_stage  = r_stage + 3'd1;
                end
            end else begin
                n_elapsed = PB'(elapsed_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PB'(ssc_pkg::RST_START_PERIOD);
            r_elapsed <= '0;
            r_stage   <= ssc_pkg::STAGE_FIRST;
            r_gear    <= ssc_pkg::GEAR_FIRST;
        end else if (i_accept) begin
            r_period  <= n_period;
            r_elapsed <= n_elapsed;
            r_stage   <= n_stage;
            r_gear    <= n_gear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_duration <= n_duration;
    end

    always_comb begin
        o_push.valid               = i_accept;
        o_push.item.phase_drive    = ssc_pkg::stage_phases(n_stage);
        o_push.item.stage_number   = n_stage;
        o_push.item.gear_number    = n_gear;
        o_push.item.current_period = 16'(n_period);
        o_push.item.stage_began    = began;
    end

endmodule

// ===== rtl/ssc_skid.sv =====
module ssc_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssc_pkg::t_push     i_push,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output ssc_pkg::t_out_item o_result
);

    logic               r_main_valid, n_main_valid;
    logic               r_skid_valid, n_skid_valid;
    ssc_pkg::t_out_item r_main,       n_main;
    ssc_pkg::t_out_item r_skid,       n_skid;
    logic               take;

    // Upstream never pushes while the skid entry is occupied
    always_comb begin
        take         = r_main_valid && !i_stall;
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push.valid;
                n_main       = i_push.item;
            end
        end else if (i_push.valid) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_push.item;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_push.item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

// ===== rtl/six_step_commutation_ramp.sv =====
// Open-loop six-step startup ramp: each accepted item (optional microsecond
// tick, optional restart) updates the stage counter, commutation stage, ramp
// period and gear, and yields exactly one result with the phase levels and
// state after that update. One item is accepted per clock while o_stall is
// low; the update is a single pass of counter, compare and subtract logic,
// and results land in a two-entry output buffer so input keeps flowing while
// one result waits. Config writes are always ready and take effect on the
// next item; write them only while the block is idle.
module six_step_commutation_ramp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ssc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output ssc_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic           accept;
    logic           skid_full;
    ssc_pkg::t_push push;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = skid_full;
    assign accept      = i_valid && !skid_full;

    ssc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push)
    );

    ssc_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (skid_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

// ===== rtl/ssc_checker.sv =====
`include "six_step_commutation_ramp_defines.svh"

module ssc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input ssc_pkg::t_out_item o_result
);

    logic out_waiting;
    logic result_in_range;
    logic phase_ok;

    assign out_waiting     = o_valid && i_stall;
    assign result_in_range = (o_result.stage_number <= ssc_pkg::STAGE_LAST) &&
                             (o_result.gear_number >= ssc_pkg::GEAR_FIRST) &&
                             (o_result.gear_number <= ssc_pkg::GEAR_SIXTH);
    assign phase_ok        = o_result.phase_drive ==
                             ssc_pkg::stage_phases(o_result.stage_number);

    // stalled result holds
    `SSC_ASSERT_NEXT(a_out_hold, out_waiting, o_valid && $stable(o_result), "result not held")

    // input stall only when a result is already waiting
    `SSC_ASSERT_NOW(a_stall_full, o_stall, o_valid, "input stalled with empty output")

    `SSC_ASSERT_NOW(a_ranges, o_valid, result_in_range, "stage or gear out of range")

    `SSC_ASSERT_NOW(a_phase_match, o_valid, phase_ok, "phase levels do not match stage")

endmodule

bind six_step_commutation_ramp ssc_checker u_ssc_checker (.*);

// ===== bench/tb_six_step_commutation_ramp.sv =====
module tb_six_step_commutation_ramp;
    timeunit 1ns;
    timeprecision 1ps;

    import ssc_pkg::*;

    localparam int CYCLE_LIMIT   = 100_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int US_PER_MS     = 1000;
    localparam int STAGES_PER_REV = 6;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 45;

    localparam logic [2:0] CFG_NO_REGISTER = 3'd7;

    // Phase levels for stages 0..5, three bits per stage, stage 0 in the low bits
    localparam logic [17:0] PHASE_LEVELS =
        {3'b110, 3'b010, 3'b011, 3'b001, 3'b101, 3'b100};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Predictor state and its copy of the registers
    logic [15:0] start_cfg;
    logic [15:0] min_cfg;
    logic [11:0] dec_cfg [NUM_DECS];
    logic [15:0] period_q;
    logic [15:0] elapsed_q;
    logic [2:0]  stage_q;
    logic [2:0]  gear_q;

    t_out_item pending_drive_q [$];
    int        mismatch_count;
    int        cycle_count;
    int        burst_left;
    bit        hold_req;

    six_step_commutation_ramp DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned stage_length(input logic [15:0] p);
        int unsigned d;
        d = (p > MS_ABOVE) ? (p / US_PER_MS) * US_PER_MS : p;
        return (d == 0) ? 1 : d;
    endfunction

    function automatic t_out_item advance_ramp(input logic tick, input logic restart);
        t_out_item   r;
        logic        began;
        logic [11:0] dec;
        began = 1'b0;
        if (restart) begin
            period_q  = start_cfg;
            gear_q    = GEAR_FIRST;
            stage_q   = STAGE_FIRST;
            elapsed_q = '0;
            began     = 1'b1;
        end else if (tick) begin
            if (int'(elapsed_q) + 1 >= stage_length(period_q)) begin
                elapsed_q = '0;
                began     = 1'b1;
                if (stage_q >= STAGE_LAST) begin
                    // end of revolution: shorten period, then latch gears
                    dec = dec_cfg[(gear_q >= GEAR_FIFTH) ? NUM_DECS - 1 : int'(gear_q) - 1];
                    if (period_q > min_cfg) begin
                        period_q = (period_q >= dec) ? period_q - dec : '0;
                    end else begin
                        period_q = min_cfg;
                    end
                    if (period_q < GEAR2_BELOW && gear_q < GEAR_SECOND) gear_q = GEAR_SECOND;
                    if (period_q < GEAR3_BELOW && gear_q < GEAR_THIRD)  gear_q = GEAR_THIRD;
                    if (period_q < GEAR4_BELOW && gear_q < GEAR_FOURTH) gear_q = GEAR_FOURTH;
                    if (period_q < GEAR5_BELOW && gear_q < GEAR_FIFTH)  gear_q = GEAR_FIFTH;
                    if (period_q < GEAR6_BELOW && gear_q < GEAR_SIXTH)  gear_q = GEAR_SIXTH;
                    stage_q = STAGE_FIRST;
                end else begin
                    stage_q = stage_q + 3'd1;
                end
            end else begin
                elapsed_q = elapsed_q + 16'd1;
            end
        end
        r.phase_drive    = PHASE_LEVELS[3 * int'(stage_q) +: 3];
        r.stage_number   = stage_q;
        r.gear_number    = gear_q;
        r.current_period = period_q;
        r.stage_began    = began;
        return r;
    endfunction

    task automatic send_item(input logic tick, input logic restart);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) != 0) begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, 5);
            end else begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_item.tick    <= tick;
        i_item.restart <= restart;
        do @(posedge i_clk); while (o_stall);
        pending_drive_q.push_back(advance_ramp(tick, restart));
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++) send_item(1'b1, 1'b0);
    endtask

    // One full revolution from stage 0 with the counter at zero
    task automatic send_revolution();
        send_ticks(STAGES_PER_REV * stage_length(period_q));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_PERIOD: start_cfg = data;
            CFG_MIN_PERIOD:   min_cfg = data;
            CFG_FIRST_DEC, CFG_SECOND_DEC, CFG_THIRD_DEC, CFG_FOURTH_DEC, CFG_FIFTH_DEC:
                dec_cfg[idx - CFG_FIRST_DEC] = data[11:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // With a start period of one, a single revolution lands the period on min
    task automatic settle_at(input logic [15:0] p);
        write_reg(CFG_MIN_PERIOD, p);
        send_item(1'b0, 1'b1);
        send_ticks(STAGES_PER_REV);
        send_ticks(2);
        wait_idle();
    endtask

    function automatic logic [15:0] pick_decrement();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'd4095;
            default: return 16'($urandom_range(0, 6));
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        // restart wins over a tick in the same transfer
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_length_stage();
        write_reg(CFG_START_PERIOD, 16'd3);
        write_reg(CFG_MIN_PERIOD, 16'd1);
        write_reg(CFG_FIRST_DEC, 16'hFFFF);    // upper bits dropped
        write_reg(CFG_NO_REGISTER, 16'h1234);  // nothing there, no effect
        send_item(1'b0, 1'b1);
        send_ticks(STAGES_PER_REV * 3);        // period saturates to zero
        send_ticks(STAGES_PER_REV);            // one-tick stages, then back to min
        send_ticks(4);
        wait_idle();
    endtask

    task automatic test_period_extremes();
        write_reg(CFG_START_PERIOD, 16'hFFFF);
        send_item(1'b0, 1'b1);
        send_ticks(3);
        wait_idle();
        write_reg(CFG_START_PERIOD, 16'd1);
        write_reg(CFG_MIN_PERIOD, 16'hFFFF);
        write_reg(CFG_FIRST_DEC, 16'd0);
        send_item(1'b1, 1'b1);
        send_ticks(STAGES_PER_REV);            // pinned at the top, gear stays first
        send_ticks(3);
        wait_idle();
    endtask

    task automatic test_ms_boundary();
        write_reg(CFG_START_PERIOD, 16'd1);
        settle_at(16'(MS_ABOVE));
        settle_at(16'(MS_ABOVE + 1));
    endtask

    task automatic test_gear_ladder();
        write_reg(CFG_START_PERIOD, 16'd1);
        settle_at(16'(GEAR2_BELOW));
        settle_at(16'(GEAR2_BELOW - 1));
        settle_at(16'(GEAR3_BELOW));
        settle_at(16'(GEAR3_BELOW - 1));
        settle_at(16'(GEAR4_BELOW));
        settle_at(16'(GEAR4_BELOW - 1));
        settle_at(16'(GEAR5_BELOW));
        settle_at(16'(GEAR5_BELOW - 1));
        settle_at(16'(GEAR6_BELOW));
        settle_at(16'(GEAR6_BELOW - 1));
        // short periods: first-gear decrement, then sixth gear uses the fifth one
        write_reg(CFG_START_PERIOD, 16'd6);
        write_reg(CFG_MIN_PERIOD, 16'd1);
        write_reg(CFG_FIRST_DEC, 16'd2);
        write_reg(CFG_FIFTH_DEC, 16'd1);
        send_item(1'b0, 1'b1);
        send_revolution();
        send_revolution();
        send_revolution();
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_START_PERIOD, 16'd4);
        write_reg(CFG_MIN_PERIOD, 16'd2);
        write_reg(CFG_FIRST_DEC, 16'd1);
        send_item(1'b0, 1'b1);
        hold_req = 1'b1;
        repeat (40) send_item(1'($urandom_range(0, 1)), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic tick;
        logic restart;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_START_PERIOD, 16'd1);
                1:       write_reg(CFG_START_PERIOD, 16'($urandom_range(13, 40)));
                default: write_reg(CFG_START_PERIOD, 16'($urandom_range(1, 12)));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_MIN_PERIOD, 16'hFFFF);
                default: write_reg(CFG_MIN_PERIOD, 16'($urandom_range(1, 4)));
            endcase
            write_reg(CFG_FIRST_DEC, pick_decrement());
            write_reg(CFG_SECOND_DEC, pick_decrement());
            write_reg(CFG_THIRD_DEC, pick_decrement());
            write_reg(CFG_FOURTH_DEC, pick_decrement());
            write_reg(CFG_FIFTH_DEC, pick_decrement());
            send_item(1'b0, 1'b1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == RANDOM_PHASES - 1) begin
                    tick    = 1'($urandom_range(0, 1));
                    restart = ($urandom_range(0, 9) == 0);
                end else begin
                    tick    = ($urandom_range(0, 9) != 0);
                    restart = ($urandom_range(0, 39) == 0);
                end
                send_item(tick, restart);
            end
            wait_idle();
        end
    endtask

    // Receiver: random stall runs, plus a long hold-off on request
    initial begin
        int   run_left;
        logic stall_now;
        i_stall   = 1'b0;
        run_left  = 0;
        stall_now = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (int n = 1; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
                stall_now = 1'b0;
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_now = 1'b0;
                        run_left  = $urandom_range(30, 80);
                    end else begin
                        stall_now = ($urandom_range(0, 3) == 0);
                        run_left  = stall_now ? $urandom_range(1, 5) : $urandom_range(1, 12);
                    end
                end
                run_left--;
                i_stall <= stall_now;
            end
        end
    end

    task automatic flag_result(input string what, input t_out_item want, input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t %s: expected drive=%b stage=%0d gear=%0d period=%0d began=%b",
                     $time, what, want.phase_drive, want.stage_number, want.gear_number,
                     want.current_period, want.stage_began);
            $display("    got drive=%b stage=%0d gear=%0d period=%0d began=%b",
                     got.phase_drive, got.stage_number, got.gear_number,
                     got.current_period, got.stage_began);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_drive_q.size() == 0) begin
                flag_result("result with nothing pending", '0, o_result);
            end else begin
                want = pending_drive_q.pop_front();
                if (o_result.phase_drive !== want.phase_drive ||
                    o_result.stage_number !== want.stage_number ||
                    o_result.gear_number !== want.gear_number ||
                    o_result.current_period !== want.current_period ||
                    o_result.stage_began !== want.stage_began) begin
                    flag_result("mismatch", want, o_result);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        burst_left  = 0;
        hold_req    = 1'b0;
        mismatch_count = 0;
        start_cfg  = RST_START_PERIOD;
        min_cfg    = RST_MIN_PERIOD;
        dec_cfg[0] = RST_FIRST_DEC;
        dec_cfg[1] = RST_SECOND_DEC;
        dec_cfg[2] = RST_THIRD_DEC;
        dec_cfg[3] = RST_FOURTH_DEC;
        dec_cfg[4] = RST_FIFTH_DEC;
        period_q   = RST_START_PERIOD;
        elapsed_q  = '0;
        stage_q    = STAGE_FIRST;
        gear_q     = GEAR_FIRST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_zero_length_stage();
        test_period_extremes();
        test_ms_boundary();
        test_gear_ladder();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
